[sv/v3alu_pkg.sv]
// Shared types, widths and fixed-point helpers of the 3D vector arithmetic unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package v3alu_pkg;

	localparam int DW        = 32;
	localparam int FRAC_BITS = 16;
	localparam int LANES     = 3;
	localparam int PW        = 2 * DW + 2;
	localparam int RAD_W     = 2 * DW;
	localparam int SQ_STEPS  = DW;
	localparam int SQ_RW     = DW + 3;
	localparam int NW        = DW + FRAC_BITS;
	localparam int DIV_STEPS = NW;

	localparam logic signed [PW-1:0] SAT_HI   = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO   = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [PW-1:0] RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
	localparam logic [DW-1:0]        DW_MAX   = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0]        DW_MIN   = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_DOT   = 4'd4,
		OP_CROSS = 4'd5,
		OP_MAG   = 4'd6,
		OP_DIST  = 4'd7,
		OP_NORM  = 4'd8
	} op_t;

	typedef struct packed {
		logic          big;
		logic          sat;
		logic [DW-1:0] val;
	} lane_out_t;

	typedef struct packed {
		op_t                       op;
		logic [LANES-1:0][DW-1:0]  vr;
		logic [LANES-1:0]          vsat;
		logic [DW-1:0]             dot;
		logic                      dot_sat;
		logic                      big;
		logic [LANES-1:0]          a_neg;
		logic [LANES-1:0]          b_neg;
		logic [LANES-1:0]          a_nz;
		logic [LANES-1:0]          b_nz;
		logic [LANES-1:0][DW-1:0]  a_mag;
		logic [LANES-1:0][DW-1:0]  b_mag;
		logic [DW-1:0]             root;
	} side_t;

	// {saturated, value}
	function automatic logic [DW:0] sat_clamp(input logic signed [PW-1:0] v);
		logic [DW:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, DW_MAX};
		end else if (v < SAT_LO) begin
			r = {1'b1, DW_MIN};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// round half up, drop the fraction, clamp
	function automatic logic [DW:0] fix_round(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = (v + RND_HALF) >>> FRAC_BITS;
		return sat_clamp(t);
	endfunction

endpackage
`default_nettype wire

[sv/v3alu_lane.sv]
// One component lane: add/sub, the three products of mul, dot, cross and squares,
// and the rounded component result. Depends on v3alu_pkg.
`default_nettype none
module v3alu_lane (
	input  logic                                clk,
	input  logic                                en,
	input  v3alu_pkg::op_t                      op,
	input  logic signed [v3alu_pkg::DW-1:0]     a_i,
	input  logic signed [v3alu_pkg::DW-1:0]     b_i,
	input  logic signed [v3alu_pkg::DW-1:0]     a_j,
	input  logic signed [v3alu_pkg::DW-1:0]     b_j,
	input  logic signed [v3alu_pkg::DW-1:0]     a_k,
	input  logic signed [v3alu_pkg::DW-1:0]     b_k,
	input  logic                                half,
	output logic signed [v3alu_pkg::PW-1:0]     p0_s2,
	output v3alu_pkg::lane_out_t                lane_o
);
	import v3alu_pkg::*;

	logic signed [DW:0]     c, sq, mx, my, sum;
	logic [DW:0]            mag;
	logic signed [PW-1:0]   p0;
	logic signed [2*DW-1:0] p1, p2;
	logic                   big;
	logic [DW:0]            rnd;

	op_t                    op_s2;
	logic signed [DW:0]     sum_s2;
	logic signed [2*DW-1:0] p1_s2, p2_s2;
	logic signed [PW-1:0]   v_s3;
	logic signed [PW-1:0]   v_d;

	always_comb begin
		if (op == OP_DIST) begin
			c = {b_i[DW-1], b_i} - {a_i[DW-1], a_i};
		end else begin
			c = {a_i[DW-1], a_i};
		end
		mag = c[DW] ? -c : c;
		big = (c[DW] ^ c[DW-1]) || (c[DW:DW-1] == 2'b11 && c[DW-2:0] == '0);
	end

	always_comb begin
		sq  = half ? {1'b0, mag[DW:1]} : c;
		case (op)
			OP_MUL, OP_DOT: begin
				mx = {a_i[DW-1], a_i};
				my = {b_i[DW-1], b_i};
			end
			default: begin
				mx = sq;
				my = sq;
			end
		endcase
		if (op == OP_SUB) begin
			sum = {a_i[DW-1], a_i} - {b_i[DW-1], b_i};
		end else begin
			sum = {a_i[DW-1], a_i} + {b_i[DW-1], b_i};
		end
	end

	assign p0 = mx * my;
	assign p1 = a_j * b_k;
	assign p2 = a_k * b_j;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op;
			sum_s2 <= sum;
			p0_s2  <= p0;
			p1_s2  <= p1;
			p2_s2  <= p2;
			v_s3   <= v_d;
		end
	end

	always_comb begin
		case (op_s2)
			OP_ADD, OP_SUB: v_d = {{(PW-DW-1){sum_s2[DW]}}, sum_s2} <<< FRAC_BITS;
			OP_CROSS:       v_d = {{(PW-2*DW){p1_s2[2*DW-1]}}, p1_s2}
			                    - {{(PW-2*DW){p2_s2[2*DW-1]}}, p2_s2};
			default:        v_d = p0_s2;
		endcase
	end

	assign rnd        = fix_round(v_s3);
	assign lane_o.big = big;
	assign lane_o.sat = rnd[DW];
	assign lane_o.val = rnd[DW-1:0];

endmodule
`default_nettype wire

[sv/v3alu_isqrt.sv]
// Pipelined floor square root, one root bit per stage, with a side word in step.
// Depends on v3alu_pkg.
`default_nettype none
module v3alu_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [v3alu_pkg::RAD_W-1:0]    in_rad,
	input  v3alu_pkg::side_t               in_side,
	output logic                           out_vld,
	output logic [v3alu_pkg::DW-1:0]       out_root,
	output v3alu_pkg::side_t               out_side
);
	import v3alu_pkg::*;

	logic [SQ_STEPS-1:0] vld_q;
	logic [SQ_RW-1:0]    rem_q  [SQ_STEPS];
	logic [SQ_RW-1:0]    rem_d  [SQ_STEPS];
	logic [SQ_RW-1:0]    prem   [SQ_STEPS];
	logic [SQ_RW-1:0]    cur    [SQ_STEPS];
	logic [SQ_RW-1:0]    trial  [SQ_STEPS];
	logic [DW-1:0]       root_q [SQ_STEPS];
	logic [DW-1:0]       root_d [SQ_STEPS];
	logic [DW-1:0]       proot  [SQ_STEPS];
	logic [RAD_W-1:0]    rad_q  [SQ_STEPS];
	logic [RAD_W-1:0]    rad_d  [SQ_STEPS];
	logic [RAD_W-1:0]    prad   [SQ_STEPS];
	side_t               side_q [SQ_STEPS];

	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				prem[k]  = '0;
				proot[k] = '0;
				prad[k]  = in_rad;
			end else begin
				prem[k]  = rem_q[k-1];
				proot[k] = root_q[k-1];
				prad[k]  = rad_q[k-1];
			end
			cur[k]   = {prem[k][SQ_RW-3:0], prad[k][RAD_W-1 -: 2]};
			trial[k] = {1'b0, proot[k], 2'b01};
			if (cur[k] >= trial[k]) begin
				rem_d[k]  = cur[k] - trial[k];
				root_d[k] = {proot[k][DW-2:0], 1'b1};
			end else begin
				rem_d[k]  = cur[k];
				root_d[k] = {proot[k][DW-2:0], 1'b0};
			end
			rad_d[k] = {prad[k][RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[SQ_STEPS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q     <= rem_d;
			root_q    <= root_d;
			rad_q     <= rad_d;
			side_q[0] <= in_side;
			for (int k = 1; k < SQ_STEPS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_vld  = vld_q[SQ_STEPS-1];
	assign out_root = root_q[SQ_STEPS-1];
	assign out_side = side_q[SQ_STEPS-1];

endmodule
`default_nettype wire

[sv/v3alu_div.sv]
// Pipelined unsigned restoring divider, three lanes side by side, one quotient
// bit per stage, with a side word in step. Depends on v3alu_pkg.
`default_nettype none
module v3alu_div (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              en,
	input  logic                                              in_vld,
	input  logic [v3alu_pkg::LANES-1:0][v3alu_pkg::NW-1:0]    in_num,
	input  logic [v3alu_pkg::LANES-1:0][v3alu_pkg::DW-1:0]    in_den,
	input  v3alu_pkg::side_t                                  in_side,
	output logic                                              out_vld,
	output logic [v3alu_pkg::LANES-1:0][v3alu_pkg::NW-1:0]    out_quo,
	output v3alu_pkg::side_t                                  out_side
);
	import v3alu_pkg::*;

	logic [DIV_STEPS-1:0]      vld_q;
	logic [LANES-1:0][DW-1:0]  rem_q  [DIV_STEPS];
	logic [LANES-1:0][DW-1:0]  rem_d  [DIV_STEPS];
	logic [LANES-1:0][DW-1:0]  prem   [DIV_STEPS];
	logic [LANES-1:0][NW-1:0]  dq_q   [DIV_STEPS];
	logic [LANES-1:0][NW-1:0]  dq_d   [DIV_STEPS];
	logic [LANES-1:0][NW-1:0]  pdq    [DIV_STEPS];
	logic [LANES-1:0][DW-1:0]  den_q  [DIV_STEPS];
	logic [LANES-1:0][DW-1:0]  pden   [DIV_STEPS];
	logic [LANES-1:0][DW:0]    cur    [DIV_STEPS];
	logic [LANES-1:0][DW:0]    diff   [DIV_STEPS];
	side_t                     side_q [DIV_STEPS];

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				prem[k] = '0;
				pdq[k]  = in_num;
				pden[k] = in_den;
			end else begin
				prem[k] = rem_q[k-1];
				pdq[k]  = dq_q[k-1];
				pden[k] = den_q[k-1];
			end
			for (int l = 0; l < LANES; l++) begin
				cur[k][l]  = {prem[k][l], pdq[k][l][NW-1]};
				diff[k][l] = cur[k][l] - {1'b0, pden[k][l]};
				if (cur[k][l] >= {1'b0, pden[k][l]}) begin
					rem_d[k][l] = diff[k][l][DW-1:0];
					dq_d[k][l]  = {pdq[k][l][NW-2:0], 1'b1};
				end else begin
					rem_d[k][l] = cur[k][l][DW-1:0];
					dq_d[k][l]  = {pdq[k][l][NW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DIV_STEPS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q     <= rem_d;
			dq_q      <= dq_d;
			den_q     <= pden;
			side_q[0] <= in_side;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_vld  = vld_q[DIV_STEPS-1];
	assign out_quo  = dq_q[DIV_STEPS-1];
	assign out_side = side_q[DIV_STEPS-1];

endmodule
`default_nettype wire

[sv/vector3_arith_unit.sv]
// 3D vector arithmetic unit, top level: three component lanes, merge of the lane
// products, square root and divider pipelines, result select and output skid.
// Depends on v3alu_pkg, v3alu_lane, v3alu_isqrt and v3alu_div.
// Every opcode runs the whole path; the 32-stage root and 48-stage divider set the depth.
// Throughput: one word per cycle, stalled while the skid register holds a word.
// Reset: arst_n clears all valid bits; the block then accepts at once.
`default_nettype none
module vector3_arith_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_scalar,
	output logic               saturated
);
	import v3alu_pkg::*;

	typedef struct packed {
		logic [LANES-1:0][DW-1:0] v;
		logic [DW-1:0]            scal;
		logic                     sat;
	} res_t;

	logic                      en;
	logic                      v_s1, v_s2, v_s3;
	op_t                       op_s1, op_s2, op_s3;
	logic [LANES-1:0][DW-1:0]  a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic                      big_s2, big_s3;
	logic signed [PW-1:0]      sum_s3;
	logic signed [PW-1:0]      p0 [LANES];
	lane_out_t                 lane_o [LANES];
	logic                      big_any, half;
	logic [DW:0]               dot_r;
	side_t                     sd;

	logic                      sq_vld;
	logic [DW-1:0]             sq_root;
	side_t                     sq_side;
	logic [DW-1:0]             len;
	logic [LANES-1:0][NW-1:0]  dnum;
	logic [LANES-1:0][DW-1:0]  dden;
	side_t                     dside;

	logic                      dv_vld;
	logic [LANES-1:0][NW-1:0]  dv_quo;
	side_t                     ds;

	logic [LANES-1:0]          neg, dz;
	logic signed [NW:0]        qs [LANES];
	logic [DW:0]               qc [LANES];
	res_t                      fin, out_q, skid_q;
	logic                      out_vld_q, skid_vld_q;

	assign en        = !skid_vld_q;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op_t'(req_type);
			a_s1   <= {a_z, a_y, a_x};
			b_s1   <= {b_z, b_y, b_x};
			op_s2  <= op_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			big_s2 <= big_any;
			op_s3  <= op_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			big_s3 <= big_s2;
			sum_s3 <= p0[0] + p0[1] + p0[2];
		end
	end

	always_comb begin
		big_any = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			big_any = big_any | lane_o[l].big;
		end
		half = big_any && (op_s1 == OP_NORM);
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		v3alu_lane u_lane (
			.clk    (clk),
			.en     (en),
			.op     (op_s1),
			.a_i    (a_s1[l]),
			.b_i    (b_s1[l]),
			.a_j    (a_s1[(l+1)%LANES]),
			.b_j    (b_s1[(l+1)%LANES]),
			.a_k    (a_s1[(l+2)%LANES]),
			.b_k    (b_s1[(l+2)%LANES]),
			.half   (half),
			.p0_s2  (p0[l]),
			.lane_o (lane_o[l])
		);
	end

	assign dot_r = fix_round(sum_s3);

	always_comb begin
		sd         = '0;
		sd.op      = op_s3;
		sd.dot     = dot_r[DW-1:0];
		sd.dot_sat = dot_r[DW];
		sd.big     = big_s3;
		for (int l = 0; l < LANES; l++) begin
			sd.vr[l]    = lane_o[l].val;
			sd.vsat[l]  = lane_o[l].sat;
			sd.a_neg[l] = a_s3[l][DW-1];
			sd.b_neg[l] = b_s3[l][DW-1];
			sd.a_nz[l]  = a_s3[l] != '0;
			sd.b_nz[l]  = b_s3[l] != '0;
			sd.a_mag[l] = a_s3[l][DW-1] ? (~a_s3[l] + 1'b1) : a_s3[l];
			sd.b_mag[l] = b_s3[l][DW-1] ? (~b_s3[l] + 1'b1) : b_s3[l];
		end
	end

	v3alu_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.in_rad   (sum_s3[RAD_W-1:0]),
		.in_side  (sd),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	always_comb begin
		len        = sq_side.big ? {sq_root[DW-2:0], 1'b0} : sq_root;
		dside      = sq_side;
		dside.root = len;
		for (int l = 0; l < LANES; l++) begin
			dnum[l] = {sq_side.a_mag[l], {FRAC_BITS{1'b0}}};
			dden[l] = (sq_side.op == OP_DIV) ? sq_side.b_mag[l] : len;
		end
	end

	v3alu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_num   (dnum),
		.in_den   (dden),
		.in_side  (dside),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (ds)
	);

	always_comb begin
		fin = '0;
		for (int l = 0; l < LANES; l++) begin
			neg[l] = (ds.op == OP_DIV) ? (ds.a_neg[l] ^ ds.b_neg[l]) : ds.a_neg[l];
			qs[l]  = neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
			qc[l]  = sat_clamp({{(PW-NW-1){qs[l][NW]}}, qs[l]});
			dz[l]  = (ds.op == OP_DIV) ? !(ds.a_nz[l] && ds.b_nz[l])
			                          : (!ds.a_nz[l] || ds.root == '0);
		end
		case (ds.op)
			OP_ADD, OP_SUB, OP_MUL, OP_CROSS: begin
				fin.v   = ds.vr;
				fin.sat = |ds.vsat;
			end
			OP_DOT: begin
				fin.scal = ds.dot;
				fin.sat  = ds.dot_sat;
			end
			OP_MAG, OP_DIST: begin
				if (ds.big || ds.root[DW-1]) begin
					fin.scal = DW_MAX;
					fin.sat  = 1'b1;
				end else begin
					fin.scal = ds.root;
				end
			end
			OP_DIV, OP_NORM: begin
				for (int l = 0; l < LANES; l++) begin
					fin.v[l] = dz[l] ? '0 : qc[l][DW-1:0];
					fin.sat  = fin.sat | (!dz[l] && qc[l][DW]);
				end
			end
			default: begin
				fin = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (res_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || res_ready) begin
			out_vld_q <= dv_vld;
		end else if (dv_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (res_ready) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || res_ready) begin
			out_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	assign res_valid  = out_vld_q;
	assign res_x      = out_q.v[0];
	assign res_y      = out_q.v[1];
	assign res_z      = out_q.v[2];
	assign res_scalar = out_q.scal;
	assign saturated  = out_q.sat;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held without an output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !res_ready))
		else $error("skid filled while output was free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !res_ready) |=> out_vld_q)
		else $error("output word dropped while stalled");

endmodule
`default_nettype wire
